>>> src/svc_pkg.sv
// shared types and constants of the silhouette voxel carver
// used by every module of the block but svc_ram; no dependencies
package svc_pkg;

    // fixed field widths
    localparam int PIX_W = 16;
    localparam int CRD_W = 5;
    localparam int MASK_W = 32;
    // internal coordinate width, covers grids up to 64
    localparam int IDX_W = 6;
    // width for comparing a coordinate against the grid size
    localparam int CMP_W = 7;
    localparam int NUM_VIEWS = 5;
    localparam int OP_QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_e;

    typedef enum logic [2:0] {
        FACE_FRONT = 3'd0,
        FACE_LEFT  = 3'd1,
        FACE_BACK  = 3'd2,
        FACE_RIGHT = 3'd3,
        FACE_TOP   = 3'd4
    } face_e;

    typedef enum logic [1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1
    } cfg_reg_e;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } back_state_e;

    // input item
    typedef struct packed {
        logic                    command;
        logic [2:0]              view_face;
        logic [CRD_W-1:0]        pixel_row;
        logic [CRD_W-1:0]        pixel_col;
        logic signed [PIX_W-1:0] pixel_value;
        logic [CRD_W-1:0]        voxel_y;
        logic [CRD_W-1:0]        voxel_z;
    } request_t;

    // result item
    typedef struct packed {
        logic [MASK_W-1:0] occupancy_mask;
        logic [CRD_W-1:0]  row_y;
        logic [CRD_W-1:0]  row_z;
    } result_t;

    // classified operation passed from front end to back end
    typedef struct packed {
        logic             is_query;
        logic [2:0]       face;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] col_rev;
        logic             keep;
        logic             in_grid;
        logic [CRD_W-1:0] vy;
        logic [CRD_W-1:0] vz;
    } op_t;

endpackage

>>> src/svc_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module svc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/svc_fifo.sv
// short operation queue between front end and back end
// depends on svc_pkg
module svc_fifo
    import svc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  op_t  wr_op,
    input  logic rd_en,
    output op_t  head,
    output logic full,
    output logic empty
);

    localparam int AW = (OP_QUEUE_DEPTH > 1) ? $clog2(OP_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(OP_QUEUE_DEPTH + 1);

    op_t           entry_reg [OP_QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == CW'(OP_QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(OP_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(OP_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

>>> src/svc_front.sv
// front end: threshold registers, item classification and address setup
// depends on svc_pkg
module svc_front
    import svc_pkg::*;
#(
    parameter int GRID_SIZE = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [PIX_W-1:0]  cfg_data,
    input  logic              push,
    input  request_t          request,
    input  logic              q_full,
    output logic              q_push,
    output op_t               q_op
);

    logic signed [PIX_W-1:0] lower_reg;
    logic signed [PIX_W-1:0] upper_reg;
    logic                    accepted;
    logic                    is_query;
    logic                    load_ok;
    logic                    query_ok;
    logic                    keep;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= 16'sh7FFF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOWER: lower_reg <= $signed(cfg_data);
                REG_UPPER: upper_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // classification
    assign accepted = push && !q_full;
    assign is_query = (request.command == CMD_QUERY);
    assign load_ok  = (request.view_face <= FACE_TOP)
                   && ({2'b00, request.pixel_row} < CMP_W'(GRID_SIZE))
                   && ({2'b00, request.pixel_col} < CMP_W'(GRID_SIZE));
    assign query_ok = ({2'b00, request.voxel_y} < CMP_W'(GRID_SIZE))
                   && ({2'b00, request.voxel_z} < CMP_W'(GRID_SIZE));
    assign keep     = (request.pixel_value > lower_reg) && (request.pixel_value < upper_reg);

    // off-image loads and loads of an unknown view are dropped here
    assign q_push = accepted && (is_query || load_ok);

    // operation for the back end
    always_comb
    begin
        q_op.is_query = is_query;
        q_op.face     = request.view_face;
        q_op.keep     = keep;
        q_op.in_grid  = query_ok;
        q_op.vy       = request.voxel_y;
        q_op.vz       = request.voxel_z;
        q_op.col_rev  = IDX_W'(GRID_SIZE - 1) - {1'b0, request.voxel_z};
        if (is_query)
        begin
            // mirrored image row for the side views, depth picks the top row
            q_op.row = IDX_W'(GRID_SIZE - 1) - {1'b0, request.voxel_y};
            q_op.col = {1'b0, request.voxel_z};
        end
        else
        begin
            q_op.row = {1'b0, request.pixel_row};
            q_op.col = {1'b0, request.pixel_col};
        end
    end

endmodule

>>> src/svc_back.sv
// back end: silhouette row memories, load read-modify-write, query combine
// depends on svc_pkg and svc_ram
module svc_back
    import svc_pkg::*;
#(
    parameter int GRID_SIZE = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  op_t     head,
    input  logic    q_empty,
    output logic    q_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam int RW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

    back_state_e                          state_reg;
    back_state_e                          state_next;
    op_t                                  op_reg;
    result_t                              res_reg;
    logic                                 res_valid_reg;
    logic                                 res_load;
    logic [NUM_VIEWS-1:0][GRID_SIZE-1:0]  valid_reg;
    logic [NUM_VIEWS-1:0]                 row_ok_reg;
    logic [NUM_VIEWS-1:0]                 rd_en;
    logic [NUM_VIEWS-1:0]                 wr_en;
    logic [RW-1:0]                        rd_addr [NUM_VIEWS];
    logic [GRID_SIZE-1:0]                 rd_data [NUM_VIEWS];
    logic [GRID_SIZE-1:0]                 row_v [NUM_VIEWS];
    logic [RW-1:0]                        wr_addr;
    logic [GRID_SIZE-1:0]                 wr_data;
    logic [GRID_SIZE-1:0]                 face_row;
    logic [GRID_SIZE-1:0]                 col_bit;
    logic [GRID_SIZE-1:0]                 back_rev;
    logic [GRID_SIZE-1:0]                 mask;
    logic [GRID_SIZE+MASK_W-1:0]          mask_ext;
    logic                                 side_ok;

    // one memory per view, GRID_SIZE rows of GRID_SIZE bits
    for (genvar v = 0; v < NUM_VIEWS; v++)
    begin : g_view
        assign rd_addr[v] = (head.is_query && (v == FACE_TOP)) ? head.col[RW-1:0]
                                                               : head.row[RW-1:0];
        // rows never written read as zero
        assign row_v[v] = row_ok_reg[v] ? rd_data[v] : '0;

        svc_ram #(
            .WIDTH (GRID_SIZE),
            .DEPTH (GRID_SIZE)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en[v]),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (rd_en[v]),
            .rd_addr (rd_addr[v]),
            .rd_data (rd_data[v])
        );

        always_ff @(posedge clk)
        begin
            if (rd_en[v])
            begin
                row_ok_reg[v] <= valid_reg[v][rd_addr[v]];
            end
        end
    end

    // sequencer: read cycle, then execute cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rd_en      = '0;
        wr_en      = '0;
        res_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_EXEC;
                    if (head.is_query)
                    begin
                        rd_en = '1;
                    end
                    else
                    begin
                        rd_en[head.face] = 1'b1;
                    end
                end
            end
            BK_EXEC:
            begin
                if (!op_reg.is_query)
                begin
                    wr_en[op_reg.face] = 1'b1;
                    state_next         = BK_IDLE;
                end
                else if (!res_valid_reg || pop)
                begin
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // operation in flight
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= head;
        end
    end

    // load: set or clear one bit of the addressed row
    assign wr_addr  = op_reg.row[RW-1:0];
    assign face_row = row_v[op_reg.face];
    assign col_bit  = GRID_SIZE'(1) << op_reg.col[RW-1:0];
    assign wr_data  = op_reg.keep ? (face_row | col_bit) : (face_row & ~col_bit);

    // row valid bits replace a clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (state_reg == BK_EXEC && !op_reg.is_query)
        begin
            valid_reg[op_reg.face][wr_addr] <= 1'b1;
        end
    end

    // query: back view is mirrored in x
    always_comb
    begin
        for (int x = 0; x < GRID_SIZE; x++)
        begin
            back_rev[x] = row_v[FACE_BACK][GRID_SIZE-1-x];
        end
    end

    assign side_ok  = row_v[FACE_LEFT][op_reg.col[RW-1:0]]
                   && row_v[FACE_RIGHT][op_reg.col_rev[RW-1:0]]
                   && op_reg.in_grid;
    assign mask     = side_ok ? (row_v[FACE_FRONT] & back_rev & row_v[FACE_TOP]) : '0;
    assign mask_ext = {{MASK_W{1'b0}}, mask};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg.occupancy_mask <= mask_ext[MASK_W-1:0];
            res_reg.row_y          <= op_reg.vy;
            res_reg.row_z          <= op_reg.vz;
        end
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

>>> src/silhouette_voxel_carver.sv
// top level of the silhouette voxel carver
// depends on svc_pkg, svc_front, svc_fifo, svc_back
//
// Five orthographic silhouettes are stored as one bit per pixel in five row
// memories of GRID_SIZE rows by GRID_SIZE bits; a pixel bit is set when
// lower_threshold < value < upper_threshold (signed Q8.8, strict). A query
// returns the x mask of voxel row (y,z) where all five views agree. The front
// end takes one item per cycle while the queue is not full, into a two-entry
// queue; the back end handles each item in a memory read cycle, then in an
// execute cycle that writes the row back for a load or fills the result
// register for a query, and takes no new item before it is done with the last.
// Dropped loads (unknown view, pixel off the image) cost the front end only.
// A query waits in the back end while the result register is occupied. Memory
// contents are not cleared after reset; per-row valid bits make unwritten rows
// read as empty, so the block is usable right after reset.
module silhouette_voxel_carver
    import svc_pkg::*;
#(
    parameter int GRID_SIZE = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    input  logic             push,
    output logic             full,
    input  request_t         request,
    output logic             empty,
    input  logic             pop,
    output result_t          result
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    op_t  q_op;
    op_t  q_head;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign full      = q_full;

    svc_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .request   (request),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_op)
    );

    svc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (q_push),
        .wr_op (q_op),
        .rd_en (q_pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    svc_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

>>> src/svc_checker.sv
// port level checks of the silhouette voxel carver, bound to the top level
// depends on svc_pkg
module svc_checker
    import svc_pkg::*;
#(
    parameter int GRID_SIZE = 32
) (
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [1:0]       cfg_index,
    input logic [PIX_W-1:0] cfg_data,
    input logic             push,
    input logic             full,
    input request_t         request,
    input logic             empty,
    input logic             pop,
    input result_t          result
);

    // in reset the result register is empty and the operation queue is not full
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not empty in reset");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    // no result can show after reset before a query has passed the queue and the back end read and execute states
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty [*3])
        else $error("result appeared too early");

    // off-grid rows carry an empty mask
    a_offgrid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (({2'b00, result.row_y} >= CMP_W'(GRID_SIZE))
                 || ({2'b00, result.row_z} >= CMP_W'(GRID_SIZE))))
        |-> (result.occupancy_mask == '0))
        else $error("off-grid row has voxels");

endmodule

bind silhouette_voxel_carver svc_checker #(
    .GRID_SIZE (GRID_SIZE)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .request   (request),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
);
